/* sv/indexed_sequence_store_macros.svh */
// assertion macros for the indexed sequence store
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ISS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/iss_pkg.sv */
// shared types and constants of the indexed sequence store
`default_nettype none

package iss_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  localparam logic [VALUE_W-1:0] NONE_VALUE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_HEAD   = 3'd1,
    OP_PUSH_TAIL  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_REVERSE    = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // what every cell does under each mode
  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,  // keep value
    MODE_OPEN  = 2'd1,  // cells above pos take left neighbor, pos loads
    MODE_CLOSE = 2'd2,  // cells at and above pos take right neighbor
    MODE_ROT   = 2'd3   // cells below pos take right neighbor, pos loads front
  } mode_e;

  typedef struct packed {
    mode_e            mode;
    logic [CNT_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] pos;
  } take_t;

endpackage

`default_nettype wire

/* sv/iss_cell.sv */
// one storage cell of the chain
`default_nettype none

module iss_cell (
  input  wire logic                        clk_i,
  input  wire logic [iss_pkg::IDX_W-1:0]   cell_idx_i,
  input  wire iss_pkg::cmd_t               cmd_i,
  input  wire logic [iss_pkg::VALUE_W-1:0] left_i,
  input  wire logic [iss_pkg::VALUE_W-1:0] right_i,
  input  wire logic [iss_pkg::VALUE_W-1:0] load_i,
  output logic      [iss_pkg::VALUE_W-1:0] data_o
);
  import iss_pkg::*;

  logic [VALUE_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]   my_pos;

  assign my_pos = CNT_W'(cell_idx_i);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.mode)
      MODE_HOLD: data_d = data_q;
      MODE_OPEN: begin
        if (my_pos == cmd_i.pos) data_d = load_i;
        else if (my_pos > cmd_i.pos) data_d = left_i;
      end
      MODE_CLOSE: begin
        if (my_pos >= cmd_i.pos) data_d = right_i;
      end
      MODE_ROT: begin
        if (my_pos == cmd_i.pos) data_d = load_i;
        else if (my_pos < cmd_i.pos) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* sv/iss_ctrl.sv */
// operation decode, count and reverse sequencer
`default_nettype none

`include "indexed_sequence_store_macros.svh"

module iss_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [iss_pkg::OP_W-1:0]     op_i,
  input  wire logic [iss_pkg::INDEX_W-1:0]  index_i,
  output iss_pkg::cmd_t                     cmd_o,
  output iss_pkg::take_t                    take_o,
  output logic                              busy_o,
  output logic                              done_o,
  output logic      [iss_pkg::STATUS_W-1:0] status_o,
  output logic      [iss_pkg::CNT_W-1:0]    cnt_o
);
  import iss_pkg::*;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_REV  = 1'b1
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;

  assign accept  = start_i && (state_q == S_IDLE);
  assign full    = (cnt_q == CNT_W'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign idx_ext = CMP_W'(index_i);
  assign cnt_ext = CMP_W'(cnt_q);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    done_d     = 1'b0;
    status_d   = ST_OK;
    cmd_o.mode = MODE_HOLD;
    cmd_o.pos  = '0;

    if (state_q == S_REV) begin
      // rotate the front entry down to its mirrored slot
      cmd_o.mode = MODE_ROT;
      cmd_o.pos  = step_q;
      if (step_q == CNT_W'(1)) begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end else begin
        step_d = step_q - CNT_W'(1);
      end
    end else if (accept) begin
      done_d = 1'b1;
      unique case (op_i)
        OP_PUSH_FRONT: begin
          if (full) status_d = ST_FULL;
          else begin
            cmd_o.mode = MODE_OPEN;
            cmd_o.pos  = '0;
            cnt_d      = cnt_q + CNT_W'(1);
          end
        end
        OP_POP_HEAD: begin
          if (empty) status_d = ST_EMPTY;
          else begin
            cmd_o.mode = MODE_CLOSE;
            cmd_o.pos  = '0;
            cnt_d      = cnt_q - CNT_W'(1);
          end
        end
        OP_PUSH_TAIL: begin
          if (full) status_d = ST_FULL;
          else begin
            cmd_o.mode = MODE_OPEN;
            cmd_o.pos  = cnt_q;
            cnt_d      = cnt_q + CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) status_d = ST_EMPTY;
          else begin
            cmd_o.mode = MODE_CLOSE;
            cmd_o.pos  = cnt_q - CNT_W'(1);
            cnt_d      = cnt_q - CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (idx_ext > cnt_ext) status_d = ST_RANGE;
          else if (full) status_d = ST_FULL;
          else begin
            cmd_o.mode = MODE_OPEN;
            cmd_o.pos  = idx_ext[CNT_W-1:0];
            cnt_d      = cnt_q + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (empty) status_d = ST_EMPTY;
          else if (idx_ext >= cnt_ext) status_d = ST_RANGE;
          else begin
            cmd_o.mode = MODE_CLOSE;
            cmd_o.pos  = idx_ext[CNT_W-1:0];
            cnt_d      = cnt_q - CNT_W'(1);
          end
        end
        OP_REVERSE: begin
          if (cnt_q >= CNT_W'(2)) begin
            cmd_o.mode = MODE_ROT;
            cmd_o.pos  = cnt_q - CNT_W'(1);
            if (cnt_q != CNT_W'(2)) begin
              done_d  = 1'b0;
              state_d = S_REV;
              step_d  = cnt_q - CNT_W'(2);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // a close removes the entry at pos
  assign take_o.en  = (cmd_o.mode == MODE_CLOSE);
  assign take_o.pos = cmd_o.pos[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      step_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      step_q   <= step_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign busy_o   = (state_q == S_REV);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign cnt_o    = cnt_q;

  `ISS_ASSERT_NEXT(a_quick_done, accept && (op_i != OP_REVERSE), done_o, "no result after op")
  `ISS_ASSERT_NOW(a_busy_no_done, busy_o, !done_o, "result while reversing")
  `ISS_ASSERT_NOW(a_cnt_cap, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
  `ISS_ASSERT_NEXT(a_cnt_idle, !accept, $stable(cnt_q), "count moved without transfer")

endmodule

`default_nettype wire

/* sv/indexed_sequence_store.sv */
// indexed sequence store: top level, chain of cells plus control
// results: done_o is registered and strobes in the cycle after its transfer, unless busy rises
// throughput: one item per cycle while busy is low; a reverse of more than two entries raises
//   busy; n entries take n-1 rotate steps in the chain, the result following the last one
// reset: rst_ni clears the count and control; entry cells are not cleared
// results are not held: done_o is high one cycle and the receiver cannot stall
`default_nettype none

module indexed_sequence_store (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [iss_pkg::OP_W-1:0]    op_i,
  input  wire logic signed [iss_pkg::VALUE_W-1:0] value_i,
  input  wire logic        [iss_pkg::INDEX_W-1:0] index_i,
  output logic                                    done_o,
  output logic signed      [iss_pkg::VALUE_W-1:0] removed_value_o,
  output logic             [iss_pkg::STATUS_W-1:0] status_o,
  output logic             [iss_pkg::COUNT_W-1:0] count_o
);
  import iss_pkg::*;

  cmd_t               cmd;
  take_t              take;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] load_data;
  logic [VALUE_W-1:0] removed_q;

  // cell data, position 0 is the front of the sequence
  logic [VALUE_W-1:0] cell_data [CAPACITY];

  iss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (op_i),
    .index_i  (index_i),
    .cmd_o    (cmd),
    .take_o   (take),
    .busy_o   (busy),
    .done_o   (done_o),
    .status_o (status_o),
    .cnt_o    (cnt)
  );

  // a rotate step moves the front entry down; pushes and inserts load the new value
  assign load_data = (cmd.mode == MODE_ROT) ? cell_data[0] : value_i;

  // the row of cells; ends of the chain feed back their own value
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] left_data;
    logic [VALUE_W-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = cell_data[g];
    end else begin : g_mid_l
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_mid_r
      assign right_data = cell_data[g+1];
    end

    iss_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .cmd_i      (cmd),
      .left_i     (left_data),
      .right_i    (right_data),
      .load_i     (load_data),
      .data_o     (cell_data[g])
    );
  end

  // removed entry is caught before the chain closes the gap
  always_ff @(posedge clk_i) begin
    if (take.en) begin
      removed_q <= cell_data[take.pos];
    end else begin
      removed_q <= NONE_VALUE;
    end
  end

  assign removed_value_o = removed_q;
  assign count_o         = COUNT_W'(cnt);

endmodule

`default_nettype wire
